// ===== rtl/aft_pkg.sv =====
// Shared types and constants for the animation frame timer.
`default_nettype none

package aft_pkg;

	// Default depth of the frame delay table.
	localparam int MAX_FRAMES_DEFAULT = 256;

	// Field and datapath widths.
	localparam int DELAY_W = 16;
	localparam int PROD_W  = 40;
	localparam int ACC_W   = 64;
	localparam int TOTAL_W = 9;
	localparam int FRAME_W = 8;
	localparam int LOOP_W  = 16;
	localparam int CFG_IDX_W = 2;

	// Time scale: one centisecond in nanoseconds, and the display time of a zero delay.
	localparam logic [23:0]       NS_PER_CS        = 24'd10000000;
	localparam logic [PROD_W-1:0] DEFAULT_FRAME_NS = 40'd100000000;

	// A loop limit of this value plays forever.
	localparam logic [LOOP_W-1:0] FOREVER_MARK = 16'hFFFF;

	// Item operation codes.
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TOTAL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_LOADED = 2'd2;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_CMP  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/animation_frame_timer.sv =====
// Animation frame timer: delay table, time accumulator and frame sequencer.
//
// Items enter on the input channel (in_valid / in_stall) and each one gives exactly
// one result on the output channel (out_valid / out_stall). A write item stores one
// frame delay in the table; a tick item adds elapsed time and advances the frame.
// Configuration registers (frame total, loop limit, loaded flag) are written on the
// cfg channel; cfg_ready is always high. The user must make writes only while idle;
// the block itself does not enforce this. One item is in work at a time: in_stall is
// high from acceptance until the result is loaded into the output register. A write
// or an ignored tick goes from idle straight to the finish state. An active tick runs
// one advance step for each frame time it subtracts plus a closing compare: every step
// reads the delay table, multiplies by 10^7 in the one shared multiplier and does
// one 64-bit compare and subtract. A tick that completes the final loop skips the
// closing compare. A finished result waits in the output register while the receiver
// stalls; the next item may be accepted then, and its result waits until the register
// frees. Reset clears the frame, the accumulator, the loop count and the configuration
// registers to their defaults; the delay table holds garbage until written.
`default_nettype none

module animation_frame_timer #(
	parameter int MAX_FRAMES = aft_pkg::MAX_FRAMES_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration write channel.
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [aft_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data,
	// Input item channel.
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          operation,
	input  wire logic [31:0]                   elapsed_ns,
	input  wire logic [7:0]                    frame_slot,
	input  wire logic [15:0]                   delay_cs,
	// Result channel.
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               frame_changed,
	output logic [7:0]                         shown_frame,
	output logic                               playback_done
);

	// Only the first 256 table entries can ever be addressed.
	localparam int DEPTH = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
	localparam int AW    = $clog2(DEPTH);

	aft_pkg::state_t state_q;

	logic [aft_pkg::TOTAL_W-1:0] frame_total_q;
	logic [aft_pkg::LOOP_W-1:0]  loop_limit_q;
	logic                        image_loaded_q;

	logic [aft_pkg::FRAME_W-1:0] current_frame_q;
	logic [aft_pkg::FRAME_W-1:0] work_frame_q;
	logic [aft_pkg::ACC_W-1:0]   acc_q;
	logic [aft_pkg::LOOP_W-1:0]  loops_q;
	logic [aft_pkg::DELAY_W-1:0] rd_delay_q;
	logic [aft_pkg::PROD_W-1:0]  prod_q;

	logic                        out_valid_q;
	logic                        frame_changed_q;
	logic [aft_pkg::FRAME_W-1:0] shown_frame_q;
	logic                        playback_done_q;

	logic [aft_pkg::DELAY_W-1:0] delay_mem [DEPTH];

	logic                        in_xfer;
	logic                        slot_ok;
	logic [aft_pkg::TOTAL_W-1:0] total;
	logic [aft_pkg::LOOP_W-1:0]  lim;
	logic                        done;
	logic                        active;
	logic [aft_pkg::PROD_W-1:0]  frame_ns;
	logic                        acc_le;
	logic                        at_last;
	logic [aft_pkg::LOOP_W-1:0]  loops_inc;
	logic                        out_free;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != aft_pkg::ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign slot_ok   = (32'(frame_slot) < MAX_FRAMES);

	// Effective frame count and loop limit as seen by the sequencer.
	assign total  = (frame_total_q > aft_pkg::TOTAL_W'(DEPTH)) ?
		aft_pkg::TOTAL_W'(DEPTH) : frame_total_q;
	assign lim    = (loop_limit_q == aft_pkg::FOREVER_MARK) ? '0 : loop_limit_q;
	assign done   = (lim != '0) && (loops_q >= lim);
	assign active = image_loaded_q && (total > aft_pkg::TOTAL_W'(1)) && !done;

	// Display time of the frame under test, and the step decisions.
	assign frame_ns  = (prod_q == '0) ? aft_pkg::DEFAULT_FRAME_NS : prod_q;
	assign acc_le    = (acc_q <= aft_pkg::ACC_W'(frame_ns));
	assign at_last   = ({1'b0, work_frame_q} + aft_pkg::TOTAL_W'(1)) >= total;
	assign loops_inc = loops_q + aft_pkg::LOOP_W'(1);
	assign out_free  = !out_valid_q || !out_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_total_q  <= aft_pkg::TOTAL_W'(1);
			loop_limit_q   <= '0;
			image_loaded_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				aft_pkg::CFG_FRAME_TOTAL:  frame_total_q  <= cfg_data[aft_pkg::TOTAL_W-1:0];
				aft_pkg::CFG_LOOP_LIMIT:   loop_limit_q   <= cfg_data[aft_pkg::LOOP_W-1:0];
				aft_pkg::CFG_IMAGE_LOADED: image_loaded_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Delay table: written on a write transfer, read by the sequencer.
	always_ff @(posedge clk) begin
		if (in_xfer && (operation == aft_pkg::OP_WRITE) && slot_ok) begin
			delay_mem[frame_slot[AW-1:0]] <= delay_cs;
		end
		if (state_q == aft_pkg::ST_READ) begin
			rd_delay_q <= delay_mem[work_frame_q[AW-1:0]];
		end
	end

	// Shared multiplier: delay in centiseconds to nanoseconds.
	always_ff @(posedge clk) begin
		if (state_q == aft_pkg::ST_MUL) begin
			prod_q <= aft_pkg::PROD_W'(rd_delay_q) * aft_pkg::PROD_W'(aft_pkg::NS_PER_CS);
		end
	end

	// Sequencer: accumulate, then subtract one frame time per pass until it fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= aft_pkg::ST_IDLE;
			current_frame_q <= '0;
			work_frame_q    <= '0;
			acc_q           <= '0;
			loops_q         <= '0;
		end else begin
			unique case (state_q)
				aft_pkg::ST_IDLE: begin
					if (in_xfer) begin
						work_frame_q <= current_frame_q;
						if ((operation == aft_pkg::OP_TICK) && active) begin
							acc_q   <= acc_q + aft_pkg::ACC_W'(elapsed_ns);
							state_q <= aft_pkg::ST_READ;
						end else begin
							state_q <= aft_pkg::ST_FIN;
						end
					end
				end
				aft_pkg::ST_READ: state_q <= aft_pkg::ST_MUL;
				aft_pkg::ST_MUL:  state_q <= aft_pkg::ST_CMP;
				aft_pkg::ST_CMP: begin
					if (acc_le) begin
						state_q <= aft_pkg::ST_FIN;
					end else begin
						acc_q <= acc_q - aft_pkg::ACC_W'(frame_ns);
						if (!at_last) begin
							work_frame_q <= work_frame_q + aft_pkg::FRAME_W'(1);
							state_q      <= aft_pkg::ST_READ;
						end else if (lim == '0) begin
							work_frame_q <= '0;
							state_q      <= aft_pkg::ST_READ;
						end else begin
							loops_q <= loops_inc;
							if (loops_inc < lim) begin
								work_frame_q <= '0;
								state_q      <= aft_pkg::ST_READ;
							end else begin
								// Final loop completed: park on the last frame.
								work_frame_q <= aft_pkg::FRAME_W'(total - aft_pkg::TOTAL_W'(1));
								state_q      <= aft_pkg::ST_FIN;
							end
						end
					end
				end
				aft_pkg::ST_FIN: begin
					if (out_free) begin
						current_frame_q <= work_frame_q;
						state_q         <= aft_pkg::ST_IDLE;
					end
				end
				default: state_q <= aft_pkg::ST_IDLE;
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == aft_pkg::ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if ((state_q == aft_pkg::ST_FIN) && out_free) begin
			frame_changed_q <= (work_frame_q != current_frame_q);
			shown_frame_q   <= work_frame_q;
			playback_done_q <= done;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_changed = frame_changed_q;
	assign shown_frame   = shown_frame_q;
	assign playback_done = playback_done_q;

	// The working frame never leaves the addressable range of the table.
	a_frame_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(work_frame_q) < DEPTH)
		else $error("working frame index beyond the delay table");

	// The loop count moves only in the compare step.
	a_loops_only_in_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != aft_pkg::ST_CMP) |=> $stable(loops_q))
		else $error("loop count changed outside the compare step");

	// The shown frame moves only when a result is loaded.
	a_frame_only_at_fin: assert property (@(posedge clk) disable iff (!arst_n)
		!((state_q == aft_pkg::ST_FIN) && out_free) |=> $stable(current_frame_q))
		else $error("current frame changed without a result");

	// The accumulator is not touched while a finished result waits to be loaded.
	a_acc_quiet_at_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aft_pkg::ST_FIN) |=> $stable(acc_q))
		else $error("accumulator changed after the advance ended");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the animation frame timer with a scoreboard class.
`timescale 1ns / 100ps

module tb;

	localparam int ITEM_GOAL   = 1250;
	localparam int CYCLE_LIMIT = 40_000_000;
	localparam int PRINT_LIMIT = 100;

	// One input item and one result item as the testbench sees them.
	typedef struct {
		logic        op;
		logic [31:0] elapsed;
		logic [7:0]  slot;
		logic [15:0] delay;
	} frame_item_t;

	typedef struct packed {
		logic       changed;
		logic [7:0] frame;
		logic       done;
	} frame_result_t;

	// Frame sequencer predictor plus the queue of results it still owes.
	class frame_scoreboard;
		logic [15:0]   delay_tab [256];
		bit            written [256];
		logic [8:0]    total_reg;
		logic [15:0]   limit_reg;
		bit            loaded_reg;
		logic [7:0]    shown_idx;
		logic [63:0]   acc_ns;
		logic [15:0]   loops;
		frame_result_t expected_frames [$];

		function new();
			foreach (written[i]) begin
				written[i] = 1'b0;
				delay_tab[i] = '0;
			end
			total_reg = 9'd1;
			limit_reg = '0;
			loaded_reg = 1'b0;
			shown_idx = '0;
			acc_ns = '0;
			loops = '0;
		endfunction

		function int unsigned eff_total();
			return (total_reg > 9'd256) ? 256 : int'(total_reg);
		endfunction

		function int unsigned eff_limit();
			return (limit_reg == aft_pkg::FOREVER_MARK) ? 0 : int'(limit_reg);
		endfunction

		function bit finished();
			return eff_limit() != 0 && int'(loops) >= eff_limit();
		endfunction

		function bit tick_acts();
			return loaded_reg && eff_total() > 1 && !finished();
		endfunction

		// True when an active tick could only reach delay entries already written.
		function bit table_ready();
			if (!written[shown_idx])
				return 1'b0;
			for (int i = 0; i < eff_total(); i++) begin
				if (!written[i])
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction

		// Display time of one frame; a zero delay means the 100 ms default.
		function logic [63:0] frame_ns(int unsigned idx);
			logic [63:0] v;
			v = 64'(delay_tab[idx]) * 64'(aft_pkg::NS_PER_CS);
			return (v == 64'd0) ? 64'(aft_pkg::DEFAULT_FRAME_NS) : v;
		endfunction

		function void write_config(logic [aft_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				aft_pkg::CFG_FRAME_TOTAL: total_reg = data[8:0];
				aft_pkg::CFG_LOOP_LIMIT: limit_reg = data[15:0];
				aft_pkg::CFG_IMAGE_LOADED: loaded_reg = data[0];
				default: ;
			endcase
		endfunction

		// Walks the accumulator through as many frames as the elapsed time covers.
		function void advance(logic [31:0] elapsed);
			int unsigned f;
			int unsigned total;
			int unsigned lim;
			logic [63:0] t;
			total = eff_total();
			lim = eff_limit();
			f = shown_idx;
			acc_ns = acc_ns + 64'(elapsed);
			forever begin
				t = frame_ns(f);
				if (acc_ns <= t)
					break;
				acc_ns = acc_ns - t;
				if (f + 1 >= total) begin
					if (lim == 0) begin
						f = 0;
					end else begin
						loops = loops + 16'd1;
						if (int'(loops) < lim) begin
							f = 0;
						end else begin
							f = total - 1;
							break;
						end
					end
				end else begin
					f++;
				end
			end
			shown_idx = f[7:0];
		endfunction

		// Notes one accepted input transfer and queues the result it must cause.
		function void note_transfer(frame_item_t it);
			frame_result_t r;
			logic [7:0] prior;
			r.changed = 1'b0;
			if (it.op == aft_pkg::OP_WRITE) begin
				delay_tab[it.slot] = it.delay;
				written[it.slot] = 1'b1;
			end else if (tick_acts()) begin
				prior = shown_idx;
				advance(it.elapsed);
				r.changed = (shown_idx != prior);
			end
			r.frame = shown_idx;
			r.done = finished();
			expected_frames.push_back(r);
		endfunction

		// Compares one result transfer with the oldest expectation; empty string if it matches.
		function string check_result(logic changed, logic [7:0] frame, logic done);
			frame_result_t e;
			string msg;
			if (expected_frames.size() == 0)
				return $sformatf("unexpected result changed=%0b frame=%0d done=%0b",
					changed, frame, done);
			e = expected_frames.pop_front();
			msg = "";
			if (changed !== e.changed)
				msg = {msg, $sformatf(" frame_changed got %0b want %0b", changed, e.changed)};
			if (frame !== e.frame)
				msg = {msg, $sformatf(" shown_frame got %0d want %0d", frame, e.frame)};
			if (done !== e.done)
				msg = {msg, $sformatf(" playback_done got %0b want %0b", done, e.done)};
			return msg;
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [aft_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]                   cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          operation = aft_pkg::OP_TICK;
	logic [31:0]                   elapsed_ns = '0;
	logic [7:0]                    frame_slot = '0;
	logic [15:0]                   delay_cs = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          frame_changed;
	logic [7:0]                    shown_frame;
	logic                          playback_done;

	frame_scoreboard sb;
	int  errors = 0;
	int  cycles = 0;
	bit  idle_on = 1'b0;
	int  stall_run = 0;

	animation_frame_timer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.elapsed_ns(elapsed_ns),
		.frame_slot(frame_slot),
		.delay_cs(delay_cs),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_changed(frame_changed),
		.shown_frame(shown_frame),
		.playback_done(playback_done)
	);

	always #5 clk = ~clk;

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		if (errors < PRINT_LIMIT)
			$display("tb: mismatch at cycle %0d:%s", cycles, msg);
		errors++;
	endtask

	// Result side: check each transfer and stall the block in random bursts.
	always @(posedge clk) begin
		string msg;
		if (arst_n && out_valid && !out_stall) begin
			msg = sb.check_result(frame_changed, shown_frame, playback_done);
			if (msg != "")
				report_mismatch(msg);
		end
		if (stall_run > 0)
			stall_run--;
		else if (idle_on && $urandom_range(0, 5) == 0)
			stall_run = $urandom_range(1, 11);
		out_stall <= (stall_run > 0);
	end

	// Presents one item, holds it until the transfer, then records it.
	task automatic send_item(frame_item_t it);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= it.op;
		elapsed_ns <= it.elapsed;
		frame_slot <= it.slot;
		delay_cs <= it.delay;
		do @(posedge clk); while (in_stall);
		sb.note_transfer(it);
	endtask

	task automatic send_tick(logic [31:0] el);
		frame_item_t it;
		it.op = aft_pkg::OP_TICK;
		it.elapsed = el;
		it.slot = 8'($urandom);
		it.delay = 16'($urandom);
		send_item(it);
	endtask

	task automatic send_write(logic [7:0] slot, logic [15:0] dly);
		frame_item_t it;
		it.op = aft_pkg::OP_WRITE;
		it.elapsed = $urandom;
		it.slot = slot;
		it.delay = dly;
		send_item(it);
	endtask

	// Waits until every result has arrived and the block has gone quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Writes all three registers back to back; valid stays high between writes.
	task automatic apply_config(logic [8:0] total, logic [15:0] limit, logic loaded);
		logic [aft_pkg::CFG_IDX_W-1:0] idx [3];
		logic [31:0] val [3];
		idx[0] = aft_pkg::CFG_FRAME_TOTAL;  val[0] = 32'(total);
		idx[1] = aft_pkg::CFG_LOOP_LIMIT;   val[1] = 32'(limit);
		idx[2] = aft_pkg::CFG_IMAGE_LOADED; val[2] = 32'(loaded);
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_config(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_delay();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 16'd0;
		else if (r < 60)
			return 16'($urandom_range(1, 6));
		else if (r < 90)
			return 16'($urandom_range(7, 40));
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic [31:0] pick_elapsed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return $urandom;
		else if (r < 30)
			return $urandom_range(0, 20_000_000);
		else if (r < 45)
			return 32'(10_000_000 * $urandom_range(0, 20));
		return $urandom_range(0, 300_000_000);
	endfunction

	// Next random item: fill delay entries an active tick could reach, else mostly ticks.
	function automatic frame_item_t next_item();
		frame_item_t it;
		int fill;
		it.elapsed = $urandom;
		it.slot = 8'($urandom);
		it.delay = pick_delay();
		fill = -1;
		if (sb.tick_acts() && !sb.table_ready()) begin
			if (!sb.written[sb.shown_idx]) begin
				fill = sb.shown_idx;
			end else begin
				for (int i = sb.eff_total() - 1; i >= 0; i--) begin
					if (!sb.written[i])
						fill = i;
				end
			end
		end
		if (fill >= 0) begin
			it.op = aft_pkg::OP_WRITE;
			it.slot = 8'(fill);
		end else if ($urandom_range(0, 3) == 0) begin
			it.op = aft_pkg::OP_WRITE;
			if (sb.eff_total() > 1 && $urandom_range(0, 4) != 0)
				it.slot = 8'($urandom_range(0, sb.eff_total() - 1));
		end else begin
			it.op = aft_pkg::OP_TICK;
			it.elapsed = pick_elapsed();
		end
		return it;
	endfunction

	initial begin
		int unsigned counted;
		int unsigned goal;
		int unsigned n;
		int unsigned lim;
		int r;
		logic [8:0] total;
		logic [15:0] limit;
		frame_item_t it;

		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: unloaded tick, table extremes, single frame, default delay.
		send_tick(32'hFFFF_FFFF);
		send_write(8'd255, 16'hFFFF);
		send_write(8'd0, 16'd0);
		send_write(8'd1, 16'd1);
		send_write(8'd2, 16'd3);
		settle();
		apply_config(9'd1, 16'd0, 1'b1);
		send_tick(32'hFFFF_FFFF);
		settle();
		// Three frames, two loops: exact default time, small steps, then finish.
		apply_config(9'd3, 16'd2, 1'b1);
		send_tick(32'd100_000_000);
		send_tick(32'd1);
		send_tick(32'd10_000_000);
		send_tick(32'hFFFF_FFFF);
		send_tick(32'd5);
		settle();
		// A raised limit resumes playback; a lowered one keeps it finished.
		apply_config(9'd3, 16'd3, 1'b1);
		send_tick(32'hFFFF_FFFF);
		settle();
		apply_config(9'd3, 16'd1, 1'b1);
		send_tick(32'd1);
		settle();
		// Frame count lowered under the shown frame, then the forever mark.
		apply_config(9'd2, 16'd0, 1'b1);
		send_tick(32'hFFFF_FFFF);
		settle();
		apply_config(9'd0, aft_pkg::FOREVER_MARK, 1'b1);
		send_tick(32'd7);
		settle();
		apply_config(9'd3, aft_pkg::FOREVER_MARK, 1'b1);
		send_tick(32'hFFFF_FFFF);
		send_tick(32'd0);
		settle();

		// Random phases, each with its own configuration.
		counted = 0;
		while (counted < ITEM_GOAL) begin
			settle();
			idle_on = (counted + 150 < ITEM_GOAL) && ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 99);
			if (r < 65)
				total = 9'($urandom_range(2, 8));
			else if (r < 80)
				total = 9'($urandom_range(9, 64));
			else if (r < 86)
				total = 9'd256;
			else if (r < 90)
				total = 9'($urandom_range(0, 1));
			else if (r < 95)
				total = 9'($urandom_range(257, 511));
			else
				total = 9'($urandom_range(0, 511));
			r = $urandom_range(0, 99);
			if (r < 40) begin
				limit = 16'd0;
			end else if (r < 55) begin
				limit = aft_pkg::FOREVER_MARK;
			end else if (r < 80) begin
				lim = int'(sb.loops) + $urandom_range(1, 3);
				limit = (lim > 65534) ? 16'd65534 : 16'(lim);
			end else if (r < 90) begin
				limit = 16'($urandom_range(1, 5));
			end else begin
				limit = 16'($urandom);
			end
			apply_config(total, limit, $urandom_range(0, 9) != 0);

			goal = $urandom_range(30, 90);
			n = 0;
			while (n < goal) begin
				it = next_item();
				send_item(it);
				n++;
				counted++;
			end
		end

		// Drain the remaining results, then give the block time to go quiet.
		idle_on = 1'b0;
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== animation_frame_timer.f =====
rtl/aft_pkg.sv
rtl/animation_frame_timer.sv
sim/tb.sv
